>>> design/srt_pkg.sv
// Shared types and codes for the session request table.
// Holds transfer structs, entry layout, controller states and command/status groups.
// No dependencies.
`timescale 1ns / 1ps

package srt_pkg;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] session_key;
        logic [31:0] request_value;
    } srt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] request_out;
        logic        hit;
    } srt_out_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] req;
    } srt_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } srt_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } srt_cmd_t;

    typedef struct packed {
        logic arg_bad;
        logic match;
        logic scan_done;
        logic out_busy;
    } srt_stat_t;

endpackage

>>> design/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module srt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/srt_ctrl.sv
// Controller state machine for the session request table.
// Sequences load, scan and commit; depends on srt_pkg.
`timescale 1ns / 1ps

module srt_ctrl
    import srt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_stall,
    input  srt_stat_t stat,
    output srt_cmd_t  cmd
);

    srt_state_t state_reg;
    srt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.arg_bad || stat.match || stat.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        op_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                op_stall = 1'b0;
                cmd.load = op_valid;
            end
            S_SCAN:
            begin
                cmd.scan = !stat.arg_bad;
            end
            S_COMMIT:
            begin
                cmd.commit = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/srt_datapath.sv
// Datapath for the session request table: operand hold, scan counters, compare,
// entry valid bits, entry RAM and result register. Depends on srt_pkg and srt_ram.
`timescale 1ns / 1ps

module srt_datapath
    import srt_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  srt_in_t   op_data,
    input  srt_cmd_t  cmd,
    output srt_stat_t stat,
    output logic      res_valid,
    input  logic      res_stall,
    output srt_out_t  res_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);

    srt_in_t            in_reg;
    logic [CNT_W-1:0]   rd_idx_reg,    rd_idx_next;
    logic               pending_reg,   pending_next;
    logic [IDX_W-1:0]   cmp_idx_reg,   cmp_idx_next;
    logic               hit_reg,       hit_next;
    logic               have_free_reg, have_free_next;
    logic [IDX_W-1:0]   free_idx_reg,  free_idx_next;
    logic [IDX_W-1:0]   tgt_idx_reg,   tgt_idx_next;
    logic [31:0]        got_req_reg,   got_req_next;
    logic [ENTRIES-1:0] valid_reg,     valid_next;
    logic               out_valid_reg, out_valid_next;
    srt_out_t           result_reg,    result_next;

    srt_entry_t         rd_entry;
    srt_entry_t         wr_entry;
    logic               issue;
    logic               entry_valid;
    logic               key_hit;
    logic               match;
    logic               arg_bad;
    logic               ram_we;
    logic [IDX_W-1:0]   wr_idx;
    logic               do_store;
    logic               do_clear;

    srt_ram #(
        .WIDTH($bits(srt_entry_t)),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .re    (issue),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    assign arg_bad = (in_reg.session_key == 32'd0)
                  || (in_reg.op != OP_STORE && in_reg.op != OP_GET && in_reg.op != OP_CLEAR)
                  || (in_reg.op != OP_GET && in_reg.request_value == 32'd0);

    assign issue       = cmd.scan && (rd_idx_reg != CNT_END);
    assign entry_valid = valid_reg[cmp_idx_reg];
    assign key_hit     = entry_valid && (rd_entry.key == in_reg.session_key);
    assign match       = cmd.scan && pending_reg && key_hit
                      && (in_reg.op != OP_CLEAR || rd_entry.req == in_reg.request_value);

    assign do_store = cmd.commit && !arg_bad && (in_reg.op == OP_STORE)
                   && (hit_reg || have_free_reg);
    assign do_clear = cmd.commit && !arg_bad && (in_reg.op == OP_CLEAR) && hit_reg;
    assign ram_we   = do_store;
    assign wr_idx   = hit_reg ? tgt_idx_reg : free_idx_reg;
    assign wr_entry = '{key: in_reg.session_key, req: in_reg.request_value};

    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        pending_next   = pending_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        have_free_next = have_free_reg;
        free_idx_next  = free_idx_reg;
        tgt_idx_next   = tgt_idx_reg;
        got_req_next   = got_req_reg;
        valid_next     = valid_reg;
        if (cmd.load)
        begin
            rd_idx_next    = '0;
            pending_next   = 1'b0;
            hit_next       = 1'b0;
            have_free_next = 1'b0;
        end
        if (cmd.scan)
        begin
            pending_next = issue;
            if (issue)
            begin
                cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                rd_idx_next  = rd_idx_reg + CNT_W'(1);
            end
            if (pending_reg && !entry_valid && !have_free_reg)
            begin
                have_free_next = 1'b1;
                free_idx_next  = cmp_idx_reg;
            end
            if (match)
            begin
                hit_next     = 1'b1;
                tgt_idx_next = cmp_idx_reg;
                got_req_next = rd_entry.req;
            end
        end
        if (do_store)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        if (do_clear)
        begin
            valid_next[tgt_idx_reg] = 1'b0;
        end
    end

    always_comb
    begin
        result_next = '{status: STAT_OK, request_out: 32'd0, hit: 1'b0};
        if (arg_bad)
        begin
            result_next.status = STAT_INVALID;
        end
        else
        begin
            case (in_reg.op)
                OP_STORE:
                begin
                    result_next.hit = hit_reg;
                    if (!hit_reg && !have_free_reg)
                    begin
                        result_next.status = STAT_FULL;
                    end
                end
                OP_GET:
                begin
                    result_next.hit = hit_reg;
                    if (hit_reg)
                    begin
                        result_next.request_out = got_req_reg;
                    end
                    else
                    begin
                        result_next.status = STAT_MISSING;
                    end
                end
                OP_CLEAR:
                begin
                    result_next.hit = hit_reg;
                end
                default:
                begin
                    result_next.status = STAT_INVALID;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            pending_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            have_free_reg <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg    <= rd_idx_next;
            pending_reg   <= pending_next;
            hit_reg       <= hit_next;
            have_free_reg <= have_free_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= op_data;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        tgt_idx_reg  <= tgt_idx_next;
        got_req_reg  <= got_req_next;
    end

    assign stat.arg_bad   = arg_bad;
    assign stat.match     = match;
    assign stat.scan_done = !pending_reg && (rd_idx_reg == CNT_END);
    assign stat.out_busy  = out_valid_reg && res_stall;

    assign res_valid = out_valid_reg;
    assign res_data  = result_reg;

endmodule

>>> design/session_request_table_top.sv
// Session request table: store, get and clear of session-to-request pairs.
// Top level joining srt_ctrl and srt_datapath; depends on srt_pkg.
//
// Operations arrive on op_valid / op_stall / op_data; one result per operation
// leaves on res_valid / res_stall / res_data. A transfer happens at a clock edge
// with valid high and stall low.
// Each operation scans the entry RAM one entry per cycle through its single
// registered read port, stopping at the first match; an invalid argument skips
// the scan and goes straight to the result. The next operation is taken the
// cycle after the result is written to the output register.
// A result waiting under res_stall does not block the next operation's scan;
// only the write-back and result load wait until the output register frees.
// Reset marks every entry empty at once through per-entry valid bits and
// drops any pending operation and result.
`timescale 1ns / 1ps

module session_request_table_top
    import srt_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     op_valid,
    output logic     op_stall,
    input  srt_in_t  op_data,
    output logic     res_valid,
    input  logic     res_stall,
    output srt_out_t res_data
);

    srt_cmd_t  cmd;
    srt_stat_t stat;

    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_stall (op_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    srt_datapath #(
        .ENTRIES(ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_data   (op_data),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

`ifndef SYNTH
    a_busy_after_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        (op_valid && !op_stall) |=> op_stall
    ) else $error("operation taken while previous one in progress");

    a_commit_free_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(res_valid && res_stall)
    ) else $error("result overwritten while held");

    a_commit_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.commit |=> res_valid
    ) else $error("commit without result");
`endif

endmodule
